[hw/rtl/point_triangle_closest_point_unit_assert.svh]
// assertion macros for the closest point unit
// expects clk and rst_n in the scope of the including module
`ifndef POINT_TRIANGLE_CLOSEST_POINT_UNIT_ASSERT_SVH
`define POINT_TRIANGLE_CLOSEST_POINT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PTCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PTCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ptcp_pkg.sv]
// shared widths, region codes and pipeline types of the closest point unit
// no dependencies
package ptcp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int XPROD_W   = 2 * DOT_W;
  localparam int WIDE_W    = XPROD_W + 2;
  localparam int WT_W      = FRAC_W + 1;
  localparam int DIV_LAT   = FRAC_W + 1;
  localparam int WP_W      = WT_W + 1 + COORD_W;
  localparam int WS_W      = WP_W + 2;
  localparam int DD_W      = COORD_W + 1;
  localparam int SQ_W      = 2 * DD_W;
  localparam int SQS_W     = SQ_W + 2;
  localparam int DIST_W    = 31;
  localparam int ROOT_IN_W = 2 * DIST_W;
  localparam int RT_W      = ROOT_IN_W + 2;
  localparam int SQ_STAGES = (ROOT_IN_W / 2 + 1) / 2;
  localparam int IN_W      = 12 * COORD_W;
  localparam int OUT_FLD_W = DIST_W + 3 * COORD_W + 3 * WT_W;
  localparam int OUT_W     = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_W - OUT_FLD_W;

  localparam logic [WT_W-1:0]   WT_ONE   = WT_W'(1) << FRAC_W;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // region of the closest point
  localparam logic [2:0] REG_VA    = 3'd0;
  localparam logic [2:0] REG_VB    = 3'd1;
  localparam logic [2:0] REG_EAB   = 3'd2;
  localparam logic [2:0] REG_VC    = 3'd3;
  localparam logic [2:0] REG_EAC   = 3'd4;
  localparam logic [2:0] REG_EBC   = 3'd5;
  localparam logic [2:0] REG_FACE  = 3'd6;
  localparam logic [2:0] REG_DEGEN = 3'd7;

  typedef logic [2:0][COORD_W-1:0] vec3_t;
  typedef logic [5:0][DOT_W-1:0]   dot6_t;

  typedef struct packed {
    vec3_t      p;
    vec3_t      a;
    vec3_t      b;
    vec3_t      c;
    logic [2:0] region;
  } side_t;

  typedef struct packed {
    vec3_t           closest;
    logic [WT_W-1:0] wa;
    logic [WT_W-1:0] wb;
    logic [WT_W-1:0] wc;
    logic            degen;
    logic            big;
  } res_t;

endpackage

[hw/rtl/point_triangle_closest_point_unit.sv]
// closest point on a triangle: top level, weights, blend, distance and output register
// depends on ptcp_pkg, ptcp_front, ptcp_div, ptcp_sqrt and the assertion macro header
//
// channel | dir | tvalid/tready | payload
// in_     | in  | request       | tdata: point, vertex a, b, c (x, y, z each)
// out_    | out | request       | tdata: distance, closest, weights; tuser: degenerate
//
// one request per cycle sustained while the output is not stalled; the pipeline has nine front
// stages, a check stage and sixteen quotient stages in the divider, six blend and distance stages,
// sixteen square root stages and the output register
// reset clears only the valid bits; data registers are left as they are
// one shared enable: a result held at the output freezes the whole pipeline,
// so in_tready drops in the same cycle and nothing is lost or repeated
module point_triangle_closest_point_unit import ptcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // point_x, point_y, point_z, vert_a_x .. vert_c_z
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // distance, closest_x/y/z, weight_a/b/c, zero fill
  output logic [0:0]       out_tuser   // degenerate
);

  `include "point_triangle_closest_point_unit_assert.svh"

  localparam logic [WS_W-1:0] RND = WS_W'(1) << (FRAC_W - 1);

  logic en;
  side_t in_side;

  logic                     f_vld;
  side_t                    f_side;
  logic signed [WIDE_W-1:0] f_num0, f_den0, f_num1, f_den1;
  logic [WT_W-1:0]          q0, q1;

  logic  dv_r  [DIV_LAT];
  side_t dsd_r [DIV_LAT];

  logic [WT_W-1:0] wa_nxt, wb_nxt, wc_nxt;
  logic            deg_nxt;

  logic            w1_vld_r;
  side_t           w1_side_r;
  logic [WT_W-1:0] w1_wa_r, w1_wb_r, w1_wc_r;
  logic            w1_deg_r;

  logic                   w2_vld_r;
  logic signed [WP_W-1:0] w2_pr_r [3][3];
  vec3_t                  w2_p_r;
  logic [WT_W-1:0]        w2_wa_r, w2_wb_r, w2_wc_r;
  logic                   w2_deg_r;

  logic            w3_vld_r;
  vec3_t           w3_p_r;
  res_t            w3_res_r;
  logic [WS_W-1:0] bsum [3];

  logic            w4_vld_r;
  logic [DD_W-1:0] w4_dd_r [3];
  res_t            w4_res_r;

  logic                   w5_vld_r;
  logic signed [SQ_W-1:0] w5_sq_r [3];
  res_t                   w5_res_r;

  logic                 w6_vld_r;
  logic [ROOT_IN_W-1:0] w6_s_r;
  res_t                 w6_res_r;
  res_t                 w6_res_nxt;
  logic [SQS_W-1:0]     sqsum;

  logic [DIST_W-1:0] root;
  logic sqv_r [SQ_STAGES];
  res_t sqd_r [SQ_STAGES];

  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  res_t              out_res_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_side.p[k] = in_tdata[k*COORD_W +: COORD_W];
      in_side.a[k] = in_tdata[(3+k)*COORD_W +: COORD_W];
      in_side.b[k] = in_tdata[(6+k)*COORD_W +: COORD_W];
      in_side.c[k] = in_tdata[(9+k)*COORD_W +: COORD_W];
    end
    in_side.region = REG_VA;
  end

  ptcp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .side_i  (in_side),
    .valid_o (f_vld),
    .side_o  (f_side),
    .num0_o  (f_num0),
    .den0_o  (f_den0),
    .num1_o  (f_num1),
    .den1_o  (f_den1)
  );

  ptcp_div u_div0 (
    .clk   (clk),
    .en    (en),
    .num_i (f_num0),
    .den_i (f_den0),
    .q_o   (q0)
  );

  ptcp_div u_div1 (
    .clk   (clk),
    .en    (en),
    .num_i (f_num1),
    .den_i (f_den1),
    .q_o   (q1)
  );

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) dv_r[i] <= 1'b0;
      for (int i = 0; i < SQ_STAGES; i++) sqv_r[i] <= 1'b0;
      w1_vld_r    <= 1'b0;
      w2_vld_r    <= 1'b0;
      w3_vld_r    <= 1'b0;
      w4_vld_r    <= 1'b0;
      w5_vld_r    <= 1'b0;
      w6_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_r[0] <= f_vld;
      for (int i = 1; i < DIV_LAT; i++) dv_r[i] <= dv_r[i-1];
      w1_vld_r <= dv_r[DIV_LAT-1];
      w2_vld_r <= w1_vld_r;
      w3_vld_r <= w2_vld_r;
      w4_vld_r <= w3_vld_r;
      w5_vld_r <= w4_vld_r;
      w6_vld_r <= w5_vld_r;
      sqv_r[0] <= w6_vld_r;
      for (int i = 1; i < SQ_STAGES; i++) sqv_r[i] <= sqv_r[i-1];
      out_valid_r <= sqv_r[SQ_STAGES-1];
    end
  end

  // weights from region and quotients
  always_comb begin
    wa_nxt  = '0;
    wb_nxt  = '0;
    wc_nxt  = '0;
    deg_nxt = 1'b0;
    case (dsd_r[DIV_LAT-1].region)
      REG_VA: wa_nxt = WT_ONE;
      REG_VB: wb_nxt = WT_ONE;
      REG_VC: wc_nxt = WT_ONE;
      REG_EAB: begin
        wb_nxt = q0;
        wa_nxt = WT_ONE - q0;
      end
      REG_EAC: begin
        wc_nxt = q0;
        wa_nxt = WT_ONE - q0;
      end
      REG_EBC: begin
        wc_nxt = q0;
        wb_nxt = WT_ONE - q0;
      end
      REG_FACE: begin
        wb_nxt = q0;
        // face weights may overshoot one after flooring
        wc_nxt = (({1'b0, q0} + {1'b0, q1}) > {1'b0, WT_ONE}) ? (WT_ONE - q0) : q1;
        wa_nxt = WT_ONE - q0 - wc_nxt;
      end
      REG_DEGEN: begin
        wa_nxt  = WT_ONE;
        deg_nxt = 1'b1;
      end
      default: wa_nxt = WT_ONE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bsum[k] = WS_W'(w2_pr_r[k][0]) + WS_W'(w2_pr_r[k][1]) + WS_W'(w2_pr_r[k][2]) + RND;
    end
    sqsum = SQS_W'(unsigned'(w5_sq_r[0])) + SQS_W'(unsigned'(w5_sq_r[1]))
          + SQS_W'(unsigned'(w5_sq_r[2]));
    w6_res_nxt     = w5_res_r;
    w6_res_nxt.big = |sqsum[SQS_W-1:ROOT_IN_W];
  end

  // datapath stages after the divider
  always_ff @(posedge clk) begin
    if (en) begin
      dsd_r[0] <= f_side;
      for (int i = 1; i < DIV_LAT; i++) dsd_r[i] <= dsd_r[i-1];

      w1_side_r <= dsd_r[DIV_LAT-1];
      w1_wa_r   <= wa_nxt;
      w1_wb_r   <= wb_nxt;
      w1_wc_r   <= wc_nxt;
      w1_deg_r  <= deg_nxt;

      for (int k = 0; k < 3; k++) begin
        w2_pr_r[k][0] <= $signed({1'b0, w1_wa_r}) * $signed(w1_side_r.a[k]);
        w2_pr_r[k][1] <= $signed({1'b0, w1_wb_r}) * $signed(w1_side_r.b[k]);
        w2_pr_r[k][2] <= $signed({1'b0, w1_wc_r}) * $signed(w1_side_r.c[k]);
      end
      w2_p_r   <= w1_side_r.p;
      w2_wa_r  <= w1_wa_r;
      w2_wb_r  <= w1_wb_r;
      w2_wc_r  <= w1_wc_r;
      w2_deg_r <= w1_deg_r;

      // round half up, then arithmetic shift by the weight fraction
      for (int k = 0; k < 3; k++) begin
        w3_res_r.closest[k] <= bsum[k][FRAC_W +: COORD_W];
      end
      w3_p_r         <= w2_p_r;
      w3_res_r.wa    <= w2_wa_r;
      w3_res_r.wb    <= w2_wb_r;
      w3_res_r.wc    <= w2_wc_r;
      w3_res_r.degen <= w2_deg_r;
      w3_res_r.big   <= 1'b0;

      for (int k = 0; k < 3; k++) begin
        w4_dd_r[k] <= {w3_p_r[k][COORD_W-1], w3_p_r[k]}
                    - {w3_res_r.closest[k][COORD_W-1], w3_res_r.closest[k]};
      end
      w4_res_r <= w3_res_r;

      for (int k = 0; k < 3; k++) begin
        w5_sq_r[k] <= $signed(w4_dd_r[k]) * $signed(w4_dd_r[k]);
      end
      w5_res_r <= w4_res_r;

      w6_s_r   <= sqsum[ROOT_IN_W-1:0];
      w6_res_r <= w6_res_nxt;

      sqd_r[0] <= w6_res_r;
      for (int i = 1; i < SQ_STAGES; i++) sqd_r[i] <= sqd_r[i-1];

      out_res_r  <= sqd_r[SQ_STAGES-1];
      out_dist_r <= sqd_r[SQ_STAGES-1].big ? DIST_MAX : root;
    end
  end

  ptcp_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .s_i    (w6_s_r),
    .root_o (root)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.wc, out_res_r.wb, out_res_r.wa,
                       out_res_r.closest[2], out_res_r.closest[1], out_res_r.closest[0],
                       out_dist_r};
  assign out_tuser  = out_res_r.degen;

  `PTCP_ASSERT_IMP(a_wsum, out_tvalid,
    ({2'b00, out_res_r.wa} + {2'b00, out_res_r.wb} + {2'b00, out_res_r.wc}) == {2'b00, WT_ONE},
    "weights do not sum to one")
  `PTCP_ASSERT_IMP(a_degen, out_tvalid && out_tuser[0],
    (out_res_r.wa == WT_ONE) && (out_res_r.wb == '0) && (out_res_r.wc == '0),
    "degenerate result without vertex a weights")
  `PTCP_ASSERT_NXT(a_tail_hold, out_tvalid && !out_tready,
    $stable(sqv_r[SQ_STAGES-1]) && out_tvalid,
    "pipeline tail moved while output stalled")

endmodule

[hw/rtl/ptcp_smul.sv]
// four-stage signed multiplier for dot-product cross terms, 34x34 partial products
// depends on ptcp_pkg
module ptcp_smul import ptcp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [DOT_W-1:0]   a_i,
  input  logic [DOT_W-1:0]   b_i,
  output logic [XPROD_W-1:0] p_o
);

  logic [2:0]          neg_r;
  logic [DOT_W-1:0]    ma_r, mb_r;
  logic [DOT_W-1:0]    pll_r, plh_r, phl_r, phh_r;
  logic [XPROD_W-1:0]  sum_r, p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= a_i[DOT_W-1] ^ b_i[DOT_W-1];
      neg_r[1] <= neg_r[0];
      neg_r[2] <= neg_r[1];
      ma_r     <= a_i[DOT_W-1] ? (~a_i + 1'b1) : a_i;
      mb_r     <= b_i[DOT_W-1] ? (~b_i + 1'b1) : b_i;
      pll_r    <= ma_r[HALF_W-1:0] * mb_r[HALF_W-1:0];
      plh_r    <= ma_r[HALF_W-1:0] * mb_r[DOT_W-1:HALF_W];
      phl_r    <= ma_r[DOT_W-1:HALF_W] * mb_r[HALF_W-1:0];
      phh_r    <= ma_r[DOT_W-1:HALF_W] * mb_r[DOT_W-1:HALF_W];
      sum_r    <= (XPROD_W'(phh_r) << DOT_W) + (XPROD_W'(plh_r) << HALF_W)
                + (XPROD_W'(phl_r) << HALF_W) + XPROD_W'(pll_r);
      p_r      <= neg_r[2] ? (~sum_r + 1'b1) : sum_r;
    end
  end

  assign p_o = p_r;

endmodule

[hw/rtl/ptcp_front.sv]
// front pipeline: edge vectors, six dot products, three cross terms, region pick
// depends on ptcp_pkg and ptcp_smul; nine register stages
module ptcp_front import ptcp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_i,
  input  side_t                    side_i,
  output logic                     valid_o,
  output side_t                    side_o,
  output logic signed [WIDE_W-1:0] num0_o,
  output logic signed [WIDE_W-1:0] den0_o,
  output logic signed [WIDE_W-1:0] num1_o,
  output logic signed [WIDE_W-1:0] den1_o
);

  localparam int PIPE = 8;
  localparam int XA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int XB [6] = '{3, 1, 1, 5, 5, 3};

  logic  vld_r [PIPE];
  side_t sd_r  [PIPE];

  logic [2:0][DIFF_W-1:0] ab_r, ac_r, ap_r, bp_r, cq_r;
  logic [2:0][DIFF_W-1:0] vx [6];
  logic [2:0][DIFF_W-1:0] vy [6];
  logic signed [PROD_W-1:0] pr_r [6][3];
  dot6_t d_r;
  dot6_t dly_r [5];
  logic [XPROD_W-1:0] xp [6];
  logic signed [WIDE_W-1:0] va_r, vb_r, vc_r;

  logic signed [WIDE_W-1:0] dw [6];
  logic signed [WIDE_W-1:0] face_den, n_bc, m_bc;
  logic signed [WIDE_W-1:0] num0_nxt, den0_nxt, num1_nxt, den1_nxt;
  logic                     c1, c2, c3, c4, c5, c6;
  logic [2:0]               region_nxt;
  side_t                    side_nxt;

  logic                     valid_r;
  side_t                    side_r;
  logic signed [WIDE_W-1:0] num0_r, den0_r, num1_r, den1_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) vld_r[i] <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= valid_i;
      for (int i = 1; i < PIPE; i++) vld_r[i] <= vld_r[i-1];
      valid_r <= vld_r[PIPE-1];
    end
  end

  // stage 1: edge and offset vectors
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_i;
      for (int i = 1; i < PIPE; i++) sd_r[i] <= sd_r[i-1];
      for (int k = 0; k < 3; k++) begin
        ab_r[k] <= {side_i.b[k][COORD_W-1], side_i.b[k]} - {side_i.a[k][COORD_W-1], side_i.a[k]};
        ac_r[k] <= {side_i.c[k][COORD_W-1], side_i.c[k]} - {side_i.a[k][COORD_W-1], side_i.a[k]};
        ap_r[k] <= {side_i.p[k][COORD_W-1], side_i.p[k]} - {side_i.a[k][COORD_W-1], side_i.a[k]};
        bp_r[k] <= {side_i.p[k][COORD_W-1], side_i.p[k]} - {side_i.b[k][COORD_W-1], side_i.b[k]};
        cq_r[k] <= {side_i.p[k][COORD_W-1], side_i.p[k]} - {side_i.c[k][COORD_W-1], side_i.c[k]};
      end
    end
  end

  // d1..d6 pair ab/ac with ap, bp, cq
  assign vx[0] = ab_r;
  assign vx[1] = ac_r;
  assign vx[2] = ab_r;
  assign vx[3] = ac_r;
  assign vx[4] = ab_r;
  assign vx[5] = ac_r;
  assign vy[0] = ap_r;
  assign vy[1] = ap_r;
  assign vy[2] = bp_r;
  assign vy[3] = bp_r;
  assign vy[4] = cq_r;
  assign vy[5] = cq_r;

  // stage 2: products, stage 3: dot sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr_r[j][k] <= $signed(vx[j][k]) * $signed(vy[j][k]);
        end
        d_r[j] <= DOT_W'(pr_r[j][0]) + DOT_W'(pr_r[j][1]) + DOT_W'(pr_r[j][2]);
      end
    end
  end

  // stages 4 to 7: cross products of dot values
  for (genvar x = 0; x < 6; x++) begin : g_xmul
    ptcp_smul u_smul (
      .clk (clk),
      .en  (en),
      .a_i (d_r[XA[x]]),
      .b_i (d_r[XB[x]]),
      .p_o (xp[x])
    );
  end

  // stage 8: va, vb, vc; dot values delayed alongside
  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= d_r;
      for (int i = 1; i < 5; i++) dly_r[i] <= dly_r[i-1];
      vc_r <= WIDE_W'($signed(xp[0])) - WIDE_W'($signed(xp[1]));
      vb_r <= WIDE_W'($signed(xp[2])) - WIDE_W'($signed(xp[3]));
      va_r <= WIDE_W'($signed(xp[4])) - WIDE_W'($signed(xp[5]));
    end
  end

  // stage 9: region tests in priority order
  always_comb begin
    for (int j = 0; j < 6; j++) dw[j] = WIDE_W'($signed(dly_r[4][j]));
    face_den = va_r + vb_r + vc_r;
    n_bc     = dw[3] - dw[2];
    m_bc     = dw[4] - dw[5];
    c1 = (dw[0] <= 0) && (dw[1] <= 0);
    c2 = (dw[2] >= 0) && (dw[3] <= dw[2]);
    c3 = (vc_r <= 0) && (dw[0] >= 0) && (dw[2] <= 0);
    c4 = (dw[5] >= 0) && (dw[4] <= dw[5]);
    c5 = (vb_r <= 0) && (dw[1] >= 0) && (dw[5] <= 0);
    c6 = (va_r <= 0) && (dw[2] <= dw[3]) && (dw[5] <= dw[4]);
    region_nxt = REG_FACE;
    num0_nxt   = '0;
    den0_nxt   = '0;
    num1_nxt   = '0;
    den1_nxt   = '0;
    if (c1) begin
      region_nxt = REG_VA;
    end else if (c2) begin
      region_nxt = REG_VB;
    end else if (c3) begin
      region_nxt = REG_EAB;
      num0_nxt   = dw[0];
      den0_nxt   = dw[0] - dw[2];
    end else if (c4) begin
      region_nxt = REG_VC;
    end else if (c5) begin
      region_nxt = REG_EAC;
      num0_nxt   = dw[1];
      den0_nxt   = dw[1] - dw[5];
    end else if (c6) begin
      region_nxt = REG_EBC;
      num0_nxt   = n_bc;
      den0_nxt   = n_bc + m_bc;
    end else if (face_den <= 0) begin
      region_nxt = REG_DEGEN;
    end else begin
      num0_nxt = vb_r;
      den0_nxt = face_den;
      num1_nxt = vc_r;
      den1_nxt = face_den;
    end
  end

  always_comb begin
    side_nxt        = sd_r[PIPE-1];
    side_nxt.region = region_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      num0_r <= num0_nxt;
      den0_r <= den0_nxt;
      num1_r <= num1_nxt;
      den1_r <= den1_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign num0_o  = num0_r;
  assign den0_o  = den0_r;
  assign num1_o  = num1_r;
  assign den1_o  = den1_r;

endmodule

[hw/rtl/ptcp_div.sv]
// pipelined fraction divider: floor(num * 2^16 / den) clamped to [0, one]
// depends on ptcp_pkg; one check stage plus one quotient bit per stage
module ptcp_div import ptcp_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WIDE_W-1:0] num_i,
  input  logic signed [WIDE_W-1:0] den_i,
  output logic [WT_W-1:0]          q_o
);

  logic [WIDE_W-1:0] rem_r  [DIV_LAT];
  logic [WIDE_W-1:0] den_r  [DIV_LAT];
  logic [FRAC_W-1:0] q_r    [DIV_LAT];
  logic              zero_r [DIV_LAT];
  logic              one_r  [DIV_LAT];

  // check stage: nonpositive operands give zero, num at or above den gives one
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_i;
      den_r[0]  <= den_i;
      q_r[0]    <= '0;
      zero_r[0] <= den_i[WIDE_W-1] || (den_i == '0) || num_i[WIDE_W-1] || (num_i == '0);
      one_r[0]  <= (den_i <= num_i);
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
    logic [WIDE_W:0]   rem2;
    logic              ge;
    logic [WIDE_W-1:0] rem_nxt;

    always_comb begin
      rem2    = {rem_r[j-1], 1'b0};
      ge      = (rem2 >= {1'b0, den_r[j-1]});
      rem_nxt = ge ? WIDE_W'(rem2 - {1'b0, den_r[j-1]}) : rem2[WIDE_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_r[j-1];
        q_r[j]    <= {q_r[j-1][FRAC_W-2:0], ge};
        zero_r[j] <= zero_r[j-1];
        one_r[j]  <= one_r[j-1];
      end
    end
  end

  assign q_o = zero_r[DIV_LAT-1] ? '0 :
               one_r[DIV_LAT-1]  ? WT_ONE : {1'b0, q_r[DIV_LAT-1]};

endmodule

[hw/rtl/ptcp_sqrt.sv]
// pipelined integer square root, two result bits per stage
// depends on ptcp_pkg
module ptcp_sqrt import ptcp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ROOT_IN_W-1:0] s_i,
  output logic [DIST_W-1:0]    root_o
);

  function automatic logic [2*RT_W-1:0] isq_step(input logic [RT_W-1:0] s,
                                                 input logic [RT_W-1:0] r,
                                                 input logic [RT_W-1:0] b);
    logic [RT_W-1:0] t;
    t = r + b;
    if (s >= t) return {s - t, (r >> 1) + b};
    return {s, r >> 1};
  endfunction

  logic [RT_W-1:0] s_r [SQ_STAGES];
  logic [RT_W-1:0] r_r [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
    localparam logic [RT_W-1:0] B1 = RT_W'(1) << (ROOT_IN_W - 4 * j);
    localparam logic [RT_W-1:0] B2 = RT_W'(1) << (ROOT_IN_W - 2 - 4 * j);
    logic [RT_W-1:0] s_in, r_in, s_mid, r_mid, s_nxt, r_nxt;

    if (j == 0) begin : g_first
      assign s_in = RT_W'(s_i);
      assign r_in = '0;
    end else begin : g_next
      assign s_in = s_r[j-1];
      assign r_in = r_r[j-1];
    end

    always_comb begin
      {s_mid, r_mid} = isq_step(s_in, r_in, B1);
      {s_nxt, r_nxt} = isq_step(s_mid, r_mid, B2);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j] <= s_nxt;
        r_r[j] <= r_nxt;
      end
    end
  end

  assign root_o = r_r[SQ_STAGES-1][DIST_W-1:0];

endmodule
